[rtl/core/ulps_pkg.sv]
// Package for the ultrasonic level smoother: widths, constants, register codes,
// the sequencer control word and its microprogram.
// No dependencies.
package ulps_pkg;

    localparam int NUM_SAMPLES = 8;
    localparam int IDX_W       = (NUM_SAMPLES > 1) ? $clog2(NUM_SAMPLES) : 1;
    localparam int CNT_W       = (IDX_W > 3) ? IDX_W : 3;
    localparam int SUM_W       = $clog2(100 * NUM_SAMPLES + 1);

    localparam int ECHO_W      = 19;
    localparam int PCT_W       = 7;
    localparam int DIST_W      = 16;
    localparam int CM_W        = 14;
    localparam int REM_W       = 23;
    localparam int RECIP_W     = 20;
    localparam int PROD_W      = ECHO_W + RECIP_W;
    localparam int RECIP_SHIFT = 25;
    localparam int PC_W        = 3;

    // echo_us / 58 (29 us per cm, halved for the round trip) as a scaled reciprocal
    localparam logic [RECIP_W-1:0] RECIP_58 = 20'd578525;

    localparam logic [PCT_W-1:0]  PCT_FULL     = 7'd100;
    localparam logic [DIST_W-1:0] DIST_MAX_RST = 16'd255;
    localparam logic [DIST_W-1:0] DIST_MIN_RST = 16'd0;
    localparam logic [CNT_W-1:0]  DIV_LAST     = CNT_W'(PCT_W - 1);
    localparam logic [CNT_W-1:0]  ACC_LAST     = CNT_W'(NUM_SAMPLES - 1);

    typedef enum logic {
        REG_DIST_MAX = 1'b0,
        REG_DIST_MIN = 1'b1
    } reg_idx_t;

    typedef enum logic [1:0] {
        COND_NONE     = 2'd0,
        COND_WAIT_IN  = 2'd1,
        COND_LOOP     = 2'd2,
        COND_OUT_BUSY = 2'd3
    } cond_t;

    typedef logic [PC_W-1:0] pc_t;

    localparam pc_t STEP_IDLE  = 3'd0;
    localparam pc_t STEP_MUL   = 3'd1;
    localparam pc_t STEP_PREP  = 3'd2;
    localparam pc_t STEP_DIV   = 3'd3;
    localparam pc_t STEP_STORE = 3'd4;
    localparam pc_t STEP_ACC   = 3'd5;
    localparam pc_t STEP_MEAN  = 3'd6;
    localparam pc_t STEP_EMIT  = 3'd7;

    typedef struct packed {
        logic  accept;
        logic  do_mul;
        logic  do_prep;
        logic  do_div;
        logic  do_store;
        logic  do_acc;
        logic  do_mean;
        logic  do_emit;
        logic  ld_div;
        logic  ld_acc;
        cond_t cond;
        pc_t   target;
    } ctrl_t;

    typedef struct packed {
        ctrl_t            word;
        logic [CNT_W-1:0] cnt;
    } seq_out_t;

    function automatic ctrl_t prog_word(input pc_t pc);
        ctrl_t w;
        w        = '0;
        w.cond   = COND_NONE;
        w.target = STEP_IDLE;
        case (pc)
            STEP_IDLE:
            begin
                w.accept = 1'b1;
                w.cond   = COND_WAIT_IN;
                w.target = STEP_IDLE;
            end
            STEP_MUL:   w.do_mul = 1'b1;
            STEP_PREP:
            begin
                w.do_prep = 1'b1;
                w.ld_div  = 1'b1;
            end
            STEP_DIV:
            begin
                w.do_div = 1'b1;
                w.cond   = COND_LOOP;
                w.target = STEP_DIV;
            end
            STEP_STORE:
            begin
                w.do_store = 1'b1;
                w.ld_acc   = 1'b1;
            end
            STEP_ACC:
            begin
                w.do_acc = 1'b1;
                w.cond   = COND_LOOP;
                w.target = STEP_ACC;
            end
            STEP_MEAN:  w.do_mean = 1'b1;
            STEP_EMIT:
            begin
                w.do_emit = 1'b1;
                w.cond    = COND_OUT_BUSY;
                w.target  = STEP_EMIT;
            end
            default: ;
        endcase
        return w;
    endfunction

endpackage

[rtl/core/ulps_seq.sv]
// Microcode sequencer: step counter, program table lookup, loop counter.
// Depends on ulps_pkg.
module ulps_seq (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              out_busy,
    output ulps_pkg::seq_out_t seq
);
    import ulps_pkg::*;

    pc_t              pc_reg;
    pc_t              pc_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    ctrl_t            word;
    logic             taken;

    assign word = prog_word(pc_reg);

    always_comb
    begin
        case (word.cond)
            COND_NONE:     taken = 1'b0;
            COND_WAIT_IN:  taken = !in_valid;
            COND_LOOP:     taken = (cnt_reg != '0);
            COND_OUT_BUSY: taken = out_busy;
            default:       taken = 1'b0;
        endcase
    end

    always_comb
    begin
        pc_next = taken ? word.target : pc_reg + 1'b1;
        if (word.ld_div)
        begin
            cnt_next = DIV_LAST;
        end
        else if (word.ld_acc)
        begin
            cnt_next = ACC_LAST;
        end
        else if (word.cond == COND_LOOP && cnt_reg != '0)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
        else
        begin
            cnt_next = cnt_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg  <= STEP_IDLE;
            cnt_reg <= '0;
        end
        else
        begin
            pc_reg  <= pc_next;
            cnt_reg <= cnt_next;
        end
    end

    assign seq.word = word;
    assign seq.cnt  = cnt_reg;

endmodule

[rtl/core/ultrasonic_level_percent_smoother_top.sv]
// Ultrasonic level smoother top: echo width to percent, ring of samples, mean.
// Depends on ulps_pkg and ulps_seq.
// A new request is taken only after the previous result has been emitted, as set
// by the sequencer program: a 7-step divide loop and one step per ring slot;
// the emit step waits while m_tvalid is held by a low m_tready.
// Reset: ring and write slot cleared, dist_max = 255, dist_min = 0.
module ultrasonic_level_percent_smoother_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [0:0]                    cfg_addr,
    input  logic [ulps_pkg::DIST_W-1:0]   cfg_wdata,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [23:0]                   s_tdata,   // [18:0] echo_us, rest zero
    input  logic                          s_tuser,   // [0] cmd
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [15:0]                   m_tdata    // [6:0] level_percent, [13:7] sample_percent
);
    import ulps_pkg::*;

    seq_out_t           seq;
    logic               out_busy;
    logic               accept_now;
    logic               emit_now;

    logic [DIST_W-1:0]  dist_max_reg;
    logic [DIST_W-1:0]  dist_min_reg;

    logic               cmd_reg;
    logic [ECHO_W-1:0]  echo_reg;
    logic [PROD_W-1:0]  prod_reg;
    logic               empty_reg;
    logic [DIST_W-1:0]  span_reg;
    logic [REM_W-1:0]   rem_reg;
    logic [PCT_W-1:0]   quo_reg;
    logic [PCT_W-1:0]   pct_reg;
    logic [SUM_W-1:0]   sum_reg;
    logic [PCT_W-1:0]   mean_reg;
    logic [PCT_W-1:0]   ring_reg [NUM_SAMPLES];
    logic [IDX_W-1:0]   slot_reg;
    logic [IDX_W-1:0]   slot_next;
    logic               m_tvalid_reg;
    logic [15:0]        m_tdata_reg;

    logic [DIST_W-1:0]  d_ext;
    logic [DIST_W-1:0]  d_clamp;
    logic [REM_W-1:0]   div_sub;
    logic               div_fits;
    logic [PCT_W-1:0]   pct_new;
    logic [PCT_W-1:0]   ring_rd;

    ulps_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .out_busy (out_busy),
        .seq      (seq)
    );

    assign out_busy   = m_tvalid_reg && !m_tready;
    assign accept_now = seq.word.accept && s_tvalid;
    assign emit_now   = seq.word.do_emit && !out_busy;
    assign s_tready   = seq.word.accept;
    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;

    // distance in cm, clamped to the configured window
    assign d_ext   = DIST_W'(prod_reg[RECIP_SHIFT +: CM_W]);
    assign d_clamp = (d_ext < dist_min_reg) ? dist_min_reg :
                     ((d_ext > dist_max_reg) ? dist_max_reg : d_ext);

    assign div_sub  = REM_W'(span_reg) << seq.cnt[2:0];
    assign div_fits = (rem_reg >= div_sub);
    assign pct_new  = empty_reg ? '0 : PCT_FULL - quo_reg;
    assign ring_rd  = ring_reg[seq.cnt[IDX_W-1:0]];

    assign slot_next = (slot_reg == IDX_W'(NUM_SAMPLES - 1)) ? '0 : slot_reg + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dist_max_reg <= DIST_MAX_RST;
            dist_min_reg <= DIST_MIN_RST;
        end
        else if (cfg_we)
        begin
            case (reg_idx_t'(cfg_addr))
                REG_DIST_MAX: dist_max_reg <= cfg_wdata;
                REG_DIST_MIN: dist_min_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept_now)
        begin
            cmd_reg  <= s_tuser;
            echo_reg <= s_tdata[ECHO_W-1:0];
        end
        if (seq.word.do_mul)
        begin
            prod_reg <= PROD_W'(echo_reg) * PROD_W'(RECIP_58);
        end
        if (seq.word.do_prep)
        begin
            empty_reg <= (dist_max_reg <= dist_min_reg);
            span_reg  <= dist_max_reg - dist_min_reg;
            rem_reg   <= REM_W'(dist_max_reg - d_clamp) * REM_W'(PCT_FULL);
            quo_reg   <= '0;
        end
        if (seq.word.do_div && div_fits)
        begin
            rem_reg <= rem_reg - div_sub;
            quo_reg <= quo_reg | (PCT_W'(1) << seq.cnt[2:0]);
        end
        if (seq.word.do_store)
        begin
            pct_reg <= pct_new;
            sum_reg <= '0;
        end
        if (seq.word.do_acc)
        begin
            sum_reg <= sum_reg + SUM_W'(ring_rd);
        end
        if (seq.word.do_mean)
        begin
            mean_reg <= PCT_W'(sum_reg / NUM_SAMPLES);
        end
        if (emit_now)
        begin
            m_tdata_reg <= {2'b00, pct_reg, mean_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_SAMPLES; i++)
            begin
                ring_reg[i] <= '0;
            end
            slot_reg <= '0;
        end
        else if (seq.word.do_store)
        begin
            if (cmd_reg)
            begin
                for (int i = 0; i < NUM_SAMPLES; i++)
                begin
                    ring_reg[i] <= pct_new;
                end
            end
            else
            begin
                ring_reg[slot_reg] <= pct_new;
                slot_reg           <= slot_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (emit_now)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

`ifndef SYNTHESIS
    a_emit_shows: assert property (@(posedge clk) disable iff (!rst_n)
        emit_now |=> m_tvalid)
        else $error("result not presented after emit step");

    a_pct_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[6:0] <= PCT_FULL && m_tdata[13:7] <= PCT_FULL))
        else $error("percent out of range");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("request accepted while previous one still in work");
`endif

endmodule
